@@ rtl/ubds_pkg.sv @@
package ubds_pkg;

    // Field widths
    localparam int BAUD_W     = 24;
    localparam int CLK_W      = 28;
    localparam int SCALE_W    = 8;
    localparam int STEP_W     = 16;
    localparam int STEP_OUT_W = 14;
    localparam int ACH_W      = 25;
    localparam int ERR_W      = 24;

    // Step unit is 2^FRAC_W
    localparam int FRAC_W = 17;
    // baud * (scale + 1), scale + 1 <= 256
    localparam int PROD_W = 32;
    // Dividend of both divisions
    localparam int NUM_W  = PROD_W + FRAC_W;
    // Quotient kept by the divider; higher bits only set a sticky overflow
    localparam int QUO_W  = 25;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    localparam logic [CLK_W-1:0] CLK_RESET = CLK_W'(25000000);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_D1_GO,
        ST_D1_WAIT,
        ST_D2_GO,
        ST_D2_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic {
        DIV_STEP,
        DIV_RATE
    } t_div_sel;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     div_start;
        t_div_sel div_sel;
        logic     save_step;
        logic     update;
        logic     next;
        logic     publish;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clk_zero;
        logic div_done;
        logic step_over;
        logic last_scale;
    } t_status;

endpackage

@@ rtl/ubds_in_if.sv @@
interface ubds_in_if;
    logic                         valid;
    logic                         ready;
    logic [ubds_pkg::BAUD_W-1:0]  target_baud;

    modport source (output valid, output target_baud, input ready);
    modport sink (input valid, input target_baud, output ready);
endinterface

@@ rtl/ubds_out_if.sv @@
interface ubds_out_if;
    logic                            valid;
    logic                            ready;
    logic [ubds_pkg::SCALE_W-1:0]    best_scale;
    logic [ubds_pkg::STEP_OUT_W-1:0] best_step;
    logic [ubds_pkg::ACH_W-1:0]      achieved_baud;
    logic [ubds_pkg::ERR_W-1:0]      baud_error;
    logic                            found;

    modport source (
        output valid, output best_scale, output best_step, output achieved_baud,
        output baud_error, output found, input ready
    );
    modport sink (
        input valid, input best_scale, input best_step, input achieved_baud,
        input baud_error, input found, output ready
    );
endinterface

@@ rtl/ubds_divider.sv @@
module ubds_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ubds_pkg::NUM_W-1:0]  i_dividend,
    input  logic [ubds_pkg::CLK_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [ubds_pkg::QUO_W-1:0]  o_quotient,
    output logic                        o_overflow,
    output logic [ubds_pkg::CLK_W-1:0]  o_remainder
);
    import ubds_pkg::*;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_dvd;
    logic [CLK_W-1:0] r_div;
    logic [CLK_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;

    logic [CLK_W:0]   w_trial;
    logic [CLK_W:0]   w_diff;
    logic             w_fits;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_dvd[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fits  = (w_trial >= {1'b0, r_div});
        n_rem   = w_fits ? w_diff[CLK_W-1:0] : w_trial[CLK_W-1:0];
    end

    // Iteration control
    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
        end else if (r_busy) begin
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Shift registers for dividend, remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NUM_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-2:0], w_fits};
            r_ovf <= r_ovf | r_quo[QUO_W-1];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_overflow  = r_ovf;
    assign o_remainder = r_rem;

endmodule

@@ rtl/ubds_datapath.sv @@
module ubds_datapath #(
    parameter int SCALE_LIMIT = 255,
    parameter int STEP_LIMIT  = 13107
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ubds_pkg::t_cmd                   i_cmd,
    output ubds_pkg::t_status                o_status,
    input  logic [ubds_pkg::BAUD_W-1:0]      i_target_baud,
    input  logic [ubds_pkg::CLK_W-1:0]       i_uart_clock,
    output logic [ubds_pkg::SCALE_W-1:0]     o_best_scale,
    output logic [ubds_pkg::STEP_OUT_W-1:0]  o_best_step,
    output logic [ubds_pkg::ACH_W-1:0]       o_achieved_baud,
    output logic [ubds_pkg::ERR_W-1:0]       o_baud_error,
    output logic                             o_found
);
    import ubds_pkg::*;

    localparam int SP1_W = $clog2(SCALE_LIMIT + 1);
    localparam int A_W   = PROD_W + 1;

    logic [BAUD_W-1:0]  r_baud;
    logic [PROD_W-1:0]  r_m;
    logic [SP1_W-1:0]   r_sp1;
    logic [CLK_W-1:0]   r_rem;
    logic [STEP_W-1:0]  r_step;
    logic [SCALE_W-1:0] r_best_scale;
    logic [STEP_W-1:0]  r_best_step;
    logic [BAUD_W-1:0]  r_best_rate;
    logic [ERR_W-1:0]   r_min_err;
    logic               r_found;

    logic [NUM_W-1:0]   w_dividend;
    logic [CLK_W-1:0]   w_divisor;
    logic               w_div_done;
    logic [QUO_W-1:0]   w_quo;
    logic               w_ovf;
    logic [CLK_W-1:0]   w_div_rem;

    logic [A_W-1:0]     w_a;
    logic [NUM_W-1:0]   w_n2;
    logic [BAUD_W-1:0]  w_rate;
    logic [ERR_W-1:0]   w_err;

    // clk*step = baud*(s+1)*2^17 - rem, so the rounded-rate numerator is
    // (2*baud*(s+1) + (s+1)) * 2^16 - rem
    always_comb begin
        w_a  = {r_m, 1'b0} + A_W'(r_sp1);
        w_n2 = {w_a, {(FRAC_W - 1){1'b0}}} - NUM_W'(r_rem);
    end

    // Divider operand select
    always_comb begin
        if (i_cmd.div_sel == DIV_STEP) begin
            w_dividend = {r_m, {FRAC_W{1'b0}}};
            w_divisor  = i_uart_clock;
        end else begin
            w_dividend = NUM_W'(w_n2[NUM_W-1:FRAC_W]);
            w_divisor  = CLK_W'(r_sp1);
        end
    end

    ubds_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_overflow  (w_ovf),
        .o_remainder (w_div_rem)
    );

    // Achieved rate never exceeds the target, so the error is target - rate
    always_comb begin
        w_rate = w_quo[BAUD_W-1:0];
        w_err  = r_baud - w_rate;
    end

    // Status back to the controller
    always_comb begin
        o_status.clk_zero   = (i_uart_clock == '0);
        o_status.div_done   = w_div_done;
        o_status.step_over  = w_ovf || (w_quo > QUO_W'(STEP_LIMIT));
        o_status.last_scale = (r_sp1 == SP1_W'(SCALE_LIMIT));
    end

    // Search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_baud       <= i_target_baud;
            r_m          <= PROD_W'(i_target_baud);
            r_sp1        <= SP1_W'(1);
            r_best_scale <= '0;
            r_best_step  <= '0;
            r_best_rate  <= '0;
            r_min_err    <= i_target_baud;
            r_found      <= 1'b0;
        end else begin
            if (i_cmd.save_step) begin
                r_step <= w_quo[STEP_W-1:0];
                r_rem  <= w_div_rem;
            end
            if (i_cmd.update && (w_err < r_min_err)) begin
                r_best_scale <= SCALE_W'(r_sp1 - SP1_W'(1));
                r_best_step  <= r_step;
                r_best_rate  <= w_rate;
                r_min_err    <= w_err;
                r_found      <= 1'b1;
            end
            if (i_cmd.next) begin
                r_m   <= r_m + PROD_W'(r_baud);
                r_sp1 <= r_sp1 + SP1_W'(1);
            end
        end
    end

    assign o_best_scale    = r_best_scale;
    assign o_best_step     = r_best_step[STEP_OUT_W-1:0];
    assign o_achieved_baud = ACH_W'(r_best_rate);
    assign o_baud_error    = r_min_err;
    assign o_found         = r_found;

endmodule

@@ rtl/ubds_ctrl.sv @@
module ubds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_free,
    input  ubds_pkg::t_status i_status,
    output ubds_pkg::t_cmd    o_cmd
);
    import ubds_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_STEP;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.clk_zero ? ST_DONE : ST_D1_GO;
                end
            end
            ST_D1_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STEP;
                n_state         = ST_D1_WAIT;
            end
            ST_D1_WAIT: begin
                if (i_status.div_done) begin
                    if (i_status.step_over) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.save_step = 1'b1;
                        n_state         = ST_D2_GO;
                    end
                end
            end
            ST_D2_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_RATE;
                n_state         = ST_D2_WAIT;
            end
            ST_D2_WAIT: begin
                o_cmd.div_sel = DIV_RATE;
                if (i_status.div_done) begin
                    o_cmd.update = 1'b1;
                    if (i_status.last_scale) begin
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.next = 1'b1;
                        n_state    = ST_D1_GO;
                    end
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/uart_baud_divisor_search.sv @@
// Baud divisor search.
// Input channel i_in carries one target baud rate per transaction; output
// channel o_out returns one transaction with the best scale/step pair, the
// achieved (rounded) baud rate, its absolute error and a found flag.
// The reference clock in hertz is written through i_cfg_we / i_cfg_wdata;
// the user must write it only while the block is idle; the block does
// not enforce this. It resets to 25 MHz. Each scale value tried takes
// two passes through one bit-serial restoring divider (49 dividend bits,
// one bit per cycle) plus sequencing. The search ends at once on a zero
// clock, else at the first step above STEP_LIMIT or after SCALE_LIMIT
// scales. One item is worked on at a time. The result sits in an output
// register; the next target is accepted while it waits. A search that
// finishes while that register is still full holds until o_out is taken.
// Reset (synchronous, active low) clears all control state and returns
// the clock register to its reset value.
module uart_baud_divisor_search #(
    parameter int SCALE_LIMIT = 255,
    parameter int STEP_LIMIT  = 13107
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ubds_pkg::CLK_W-1:0]     i_cfg_wdata,
    ubds_in_if.sink                        i_in,
    ubds_out_if.source                     o_out
);
    import ubds_pkg::*;

    logic [CLK_W-1:0]      r_clk;
    logic                  r_out_valid;
    logic [SCALE_W-1:0]    r_out_scale;
    logic [STEP_OUT_W-1:0] r_out_step;
    logic [ACH_W-1:0]      r_out_ach;
    logic [ERR_W-1:0]      r_out_err;
    logic                  r_out_found;

    t_cmd                  w_cmd;
    t_status               w_status;
    logic                  w_out_free;
    logic [SCALE_W-1:0]    w_scale;
    logic [STEP_OUT_W-1:0] w_step;
    logic [ACH_W-1:0]      w_ach;
    logic [ERR_W-1:0]      w_err;
    logic                  w_found;

    // Reference clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk <= CLK_RESET;
        end else if (i_cfg_we) begin
            r_clk <= i_cfg_wdata;
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    ubds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_out_free (w_out_free),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ubds_datapath #(
        .SCALE_LIMIT (SCALE_LIMIT),
        .STEP_LIMIT  (STEP_LIMIT)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_target_baud   (i_in.target_baud),
        .i_uart_clock    (r_clk),
        .o_best_scale    (w_scale),
        .o_best_step     (w_step),
        .o_achieved_baud (w_ach),
        .o_baud_error    (w_err),
        .o_found         (w_found)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_cmd.publish) begin
            r_out_scale <= w_scale;
            r_out_step  <= w_step;
            r_out_ach   <= w_ach;
            r_out_err   <= w_err;
            r_out_found <= w_found;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.best_scale    = r_out_scale;
    assign o_out.best_step     = r_out_step;
    assign o_out.achieved_baud = r_out_ach;
    assign o_out.baud_error    = r_out_err;
    assign o_out.found         = r_out_found;

endmodule
